FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset
`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int DATA_W     = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CAP_DEF    = 32;
  localparam int CAP_MAX    = 64;
  // Width of a count or position on the broadcast bus, sized for the largest list
  localparam int CNT_MAX_W  = $clog2(CAP_MAX + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_POP    = 3'd2,
    KIND_DUMP   = 3'd3,
    KIND_INSERT = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_ADD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e               op;
    logic [DATA_W-1:0]      value;
    logic [CNT_MAX_W-1:0]   pos;
    logic [CNT_MAX_W-1:0]   cnt;
  } cell_ctl_t;

endpackage

FILE: rtl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element and updates it from the broadcast command,
// its left or right neighbor, or the head of the chain.
// ----------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] head_i,
  output logic [DATA_W-1:0] elem_o
);

  localparam logic [CNT_MAX_W-1:0] Idx     = CNT_MAX_W'(IDX);
  localparam logic [CNT_MAX_W-1:0] IdxNext = CNT_MAX_W'(IDX + 1);

  logic [DATA_W-1:0] elem_q, elem_d;

  // Select the next element value
  always_comb begin
    elem_d = elem_q;
    case (ctl_i.op)
      CELL_APPEND: begin
        if (Idx == ctl_i.cnt) elem_d = ctl_i.value;
      end
      CELL_ADD: begin
        if (Idx < ctl_i.cnt) elem_d = elem_q + ctl_i.value;
      end
      CELL_INSERT: begin
        if (Idx == ctl_i.pos) begin
          elem_d = ctl_i.value;
        end else if (Idx > ctl_i.pos && Idx <= ctl_i.cnt) begin
          elem_d = left_i;
        end
      end
      CELL_ROTATE: begin
        // Wrap the head into the last held slot, shift the rest down
        if (IdxNext == ctl_i.cnt) begin
          elem_d = head_i;
        end else if (Idx < ctl_i.cnt) begin
          elem_d = right_i;
        end
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

FILE: rtl/indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Bounded ordered list of 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Results: the first result is loaded into the output register as its
//   transaction is accepted; dump results follow one per cycle unless stalled.
// Throughput: one item per cycle for append, add-to-all, pop and insert while
//   the output is not stalled; a dump blocks the input until its last element
//   is emitted, one element per cycle as the chain rotates through its head.
// Reset: count and handshake state clear at once; element cells are not reset.
`include "assert_macros.svh"

module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY = CAP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic signed [DATA_W-1:0]   value_i,
  input  logic [POS_W-1:0]           position_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [DATA_W-1:0]   element_o,
  output logic [POS_W-1:0]           element_index_o,
  output logic                       last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [DW-1:0]     dptr_q, dptr_d;

  logic              out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] element_q, element_d;
  logic [POS_W-1:0]  index_q, index_d;
  logic              last_q, last_d;
  logic              load;

  logic              slot_free, in_fire, empty, full, dump_go;
  logic [DW-1:0]     dump_idx;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data [CAPACITY];

  // Chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[g+1];
    end
    ile_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left),
      .right_i(right),
      .head_i (cell_data[0]),
      .elem_o (cell_data[g])
    );
  end

  // Handshake
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CapCount);
  assign dump_go    = ((state_q == ST_DUMP) && slot_free) ||
                      (in_fire && kind_i == KIND_DUMP && !empty);
  assign dump_idx   = (state_q == ST_DUMP) ? dptr_q : '0;

  // Decode the transaction into a cell command and a result
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = value_i;
    ctl.pos   = CNT_MAX_W'(position_i);
    ctl.cnt   = CNT_MAX_W'(count_q);
    count_d   = count_q;
    state_d   = state_q;
    dptr_d    = dptr_q;
    load      = 1'b0;
    status_d  = STATUS_OK;
    element_d = '0;
    index_d   = '0;
    last_d    = 1'b1;
    if (dump_go) begin
      // Emit the head element and rotate the held elements by one
      ctl.op    = CELL_ROTATE;
      load      = 1'b1;
      element_d = cell_data[0];
      index_d   = POS_W'(dump_idx);
      last_d    = ((CW'(dump_idx) + CW'(1)) == count_q);
      if (last_d) begin
        state_d = ST_IDLE;
        dptr_d  = '0;
      end else begin
        state_d = ST_DUMP;
        dptr_d  = dump_idx + DW'(1);
      end
    end else if (in_fire) begin
      load = 1'b1;
      case (kind_i)
        KIND_APPEND: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctl.op  = CELL_APPEND;
            count_d = count_q + CW'(1);
          end
        end
        KIND_ADD: ctl.op = CELL_ADD;
        KIND_POP: begin
          if (empty) status_d = STATUS_EMPTY;
          else       count_d  = count_q - CW'(1);
        end
        KIND_DUMP: status_d = STATUS_EMPTY;
        KIND_INSERT: begin
          if (CNT_MAX_W'(position_i) > CNT_MAX_W'(count_q)) begin
            status_d = STATUS_BADPOS;
          end else if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctl.op  = CELL_INSERT;
            count_d = count_q + CW'(1);
          end
        end
        default: status_d = STATUS_OK;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dptr_q  <= dptr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      element_q <= element_d;
      index_q   <= index_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign element_o       = element_q;
  assign element_index_o = index_q;
  assign last_o          = last_q;

  // Checks
  `ASSERT_NEVER(a_count_bound, count_q > CapCount)
  `ASSERT_HOLDS(a_dump_blocks_in, (state_q == ST_DUMP) |-> !in_ready_o)
  `ASSERT_HOLDS(a_accept_gives_result, (in_valid_i && in_ready_o) |=> out_valid_o)
  `ASSERT_HOLDS(a_count_steady_in_dump, (state_q == ST_DUMP) |=> $stable(count_q))

endmodule

FILE: tb/sv/tb_indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_engine_top
// Self-checking bench for the indexed list engine. A queue-fed driver pushes
// append, add-to-all, pop, dump, insert and undefined operations. A shadow
// copy of the list predicts every result. A monitor compares each output
// transaction field by field, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_top;
  import ile_pkg::*;

  localparam int LIST_CAP = CAP_DEF;
  localparam int ITEMS_PER_PHASE = 75;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } list_op_t;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         elem_index;
    logic                     last;
  } list_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [KIND_W-1:0]          kind_i = '0;
  logic signed [DATA_W-1:0]   value_i = '0;
  logic [POS_W-1:0]           position_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [STATUS_W-1:0]        status_o;
  logic signed [DATA_W-1:0]   element_o;
  logic [POS_W-1:0]           element_index_o;
  logic                       last_o;

  // Stimulus backlog, shadow list and expected outputs
  list_op_t                   op_backlog[$];
  list_result_t               awaited_results[$];
  logic signed [DATA_W-1:0]   shadow_cells[LIST_CAP];
  int                         shadow_count = 0;
  int                         plan_count = 0;
  bit                         filling = 1'b1;

  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  logic                       in_taken = 1'b0;

  int                         fail_count = 0;
  int                         ops_accepted = 0;
  int                         results_checked = 0;
  int                         status_hits[4] = '{0, 0, 0, 0};

  indexed_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .element_o      (element_o),
    .element_index_o(element_index_o),
    .last_o         (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one list operation to the shadow list and queue its results
  task automatic predict_list_op(input list_op_t op);
    list_result_t r;
    int           i;
    r = '{status: STATUS_OK, element: '0, elem_index: '0, last: 1'b1};
    case (op.kind)
      KIND_APPEND: begin
        if (shadow_count >= LIST_CAP) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_cells[shadow_count] = op.value;
          shadow_count++;
        end
      end
      KIND_ADD: begin
        for (i = 0; i < shadow_count; i++) shadow_cells[i] = shadow_cells[i] + op.value;
      end
      KIND_POP: begin
        if (shadow_count == 0) r.status = STATUS_EMPTY;
        else shadow_count--;
      end
      KIND_DUMP: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            r.element    = shadow_cells[i];
            r.elem_index = i[POS_W-1:0];
            r.last       = (i == shadow_count - 1);
            awaited_results.push_back(r);
          end
          return;
        end
      end
      KIND_INSERT: begin
        if (op.pos > shadow_count) begin
          r.status = STATUS_BADPOS;
        end else if (shadow_count >= LIST_CAP) begin
          r.status = STATUS_FULL;
        end else begin
          for (i = shadow_count; i > op.pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[op.pos] = op.value;
          shadow_count++;
        end
      end
      default: begin
      end
    endcase
    awaited_results.push_back(r);
  endtask

  // Queue one operation and track the list length it leads to
  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
                          input int pos);
    op_backlog.push_back('{kind: kind, value: value, pos: pos[POS_W-1:0]});
    case (kind)
      KIND_APPEND: if (plan_count < LIST_CAP) plan_count++;
      KIND_POP:    if (plan_count > 0) plan_count--;
      KIND_INSERT: if (pos <= plan_count && plan_count < LIST_CAP) plan_count++;
      default: begin
      end
    endcase
  endtask

  // Pick a value, now and then one at the edge of the signed range
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15, 0))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Queue one random operation; return 1 unless the kind is undefined
  task automatic queue_random_op(output bit counted);
    int                roll;
    int                pos;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(99, 0);
    // Swing between filling up to capacity and draining down to empty
    if (filling && plan_count == LIST_CAP && $urandom_range(5, 0) == 0) filling = 1'b0;
    if (!filling && plan_count == 0 && $urandom_range(3, 0) == 0) filling = 1'b1;
    if (roll < 4) kind = KIND_W'($urandom_range(7, KIND_INSERT + 1));
    else if (roll < 12) kind = KIND_DUMP;
    else if (roll < 22) kind = KIND_ADD;
    else if (filling) kind = (roll < 30) ? KIND_POP : (roll < 70) ? KIND_APPEND : KIND_INSERT;
    else kind = (roll < 70) ? KIND_POP : (roll < 85) ? KIND_APPEND : KIND_INSERT;
    if (kind == KIND_INSERT && $urandom_range(99, 0) < 85) pos = $urandom_range(plan_count, 0);
    else pos = $urandom_range((1 << POS_W) - 1, 0);
    queue_op(kind, pick_value(), pos);
    counted = (kind <= KIND_INSERT);
  endtask

  // Wait until every queued operation is in and every result is out
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: present the next operation, hold it until taken, idle at random
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (op_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        kind_i     <= op_backlog[0].kind;
        value_i    <= op_backlog[0].value;
        position_i <= op_backlog[0].pos;
        op_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Monitor: check each output transaction, predict each input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d element %0d index %0d last %0d",
                 status_o, element_o, element_index_o, last_o);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          results_checked++;
          status_hits[status_o]++;
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status_o);
            fail_count++;
          end
          if (element_o !== exp_r.element) begin
            $error("element: expected %0d, actual %0d", exp_r.element, element_o);
            fail_count++;
          end
          if (element_index_o !== exp_r.elem_index) begin
            $error("element_index: expected %0d, actual %0d", exp_r.elem_index,
                   element_index_o);
            fail_count++;
          end
          if (last_o !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, last_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        ops_accepted++;
        predict_list_op('{kind: kind_i, value: value_i, pos: position_i});
      end
    end
  end

  // Main sequence: reset, directed cases, then random phases
  initial begin
    int  send_mix[4];
    int  recv_mix[4];
    int  phase;
    int  done_ops;
    bit  counted;
    send_mix = '{0, 86, 0, 11};
    recv_mix = '{0, 0, 86, 11};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list corners, then edge values, inserts at both ends and middle
    queue_op(KIND_DUMP, '0, 0);
    queue_op(KIND_POP, '0, 0);
    queue_op(KIND_ADD, 32'sd5, 0);
    queue_op(KIND_INSERT, 32'sd9, 1);
    queue_op(KIND_INSERT, 32'sd9, (1 << POS_W) - 1);
    queue_op(KIND_INSERT, VAL_MIN, 0);
    queue_op(KIND_APPEND, VAL_MAX, 0);
    queue_op(KIND_APPEND, '0, 0);
    queue_op(KIND_INSERT, 32'sd77, 3);
    queue_op(KIND_INSERT, -32'sd1, 1);
    queue_op(KIND_DUMP, '0, 0);
    queue_op(KIND_ADD, 32'sd1, 0);
    queue_op(KIND_DUMP, '0, 0);
    queue_op(KIND_ADD, -32'sd1, 0);
    queue_op(KIND_POP, '0, 0);
    queue_op(KIND_W'(KIND_INSERT + 1), 32'sd3, 0);
    queue_op(KIND_W'(KIND_INSERT + 2), VAL_MAX, (1 << POS_W) - 1);
    queue_op(KIND_W'(KIND_INSERT + 3), VAL_MIN, 0);
    queue_op(KIND_DUMP, '0, 0);
    queue_op(KIND_INSERT, 32'sd4, 5);
    queue_op(KIND_ADD, VAL_MIN, 0);
    queue_op(KIND_DUMP, '0, 0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_mix[phase];
      recv_stall_pct = recv_mix[phase];
      done_ops = 0;
      while (done_ops < ITEMS_PER_PHASE) begin
        queue_random_op(counted);
        if (counted) done_ops++;
      end
      wait_drained();
    end

    // Let any stray output show up before judging
    repeat (8) @(posedge clk_i);
    $display("covered %0d input transactions and %0d results in four idle/stall mixes",
             ops_accepted, results_checked);
    $display("statuses seen: ok %0d, empty %0d, bad position %0d, full %0d",
             status_hits[STATUS_OK], status_hits[STATUS_EMPTY], status_hits[STATUS_BADPOS],
             status_hits[STATUS_FULL]);
    if (fail_count == 0) begin
      $display("tb_indexed_list_engine_top: PASS");
    end else begin
      $display("tb_indexed_list_engine_top: FAIL");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #2000000;
    $display("tb_indexed_list_engine_top: FAIL");
    $finish;
  end

endmodule
